FILE: rtl/rotate_point_about_center_macros.svh
// ----------------------------------------------------------------------------
// rotate_point_about_center_macros
// assertion helpers shared by the rotate block
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_CENTER_MACROS_SVH
`define ROTATE_POINT_ABOUT_CENTER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RPC_CHECK_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset
`define RPC_CHECK_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// types, constants and helpers of the point rotation pipeline
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int COORD_WIDTH     = 32;
    localparam int GUARD_BITS      = 16;

    localparam int FIELD_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int MAX_STAGES = 32;
    localparam int TURN_W     = 32;

    localparam int CW = (COORD_WIDTH < 2) ? 2 :
                        ((COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH);
    localparam int N_STAGES = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;

    // cordic gain 1/K in Q30
    localparam int GAIN_W    = 30;
    localparam int GAIN_FRAC = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;

    localparam int MUL_SPLIT  = 16;
    localparam int MAG_W      = CW + 1;
    localparam int MAG_HI_W   = MAG_W - MUL_SPLIT;
    localparam int PROD_HI_W  = MAG_HI_W + GAIN_W;
    localparam int PROD_LO_W  = MUL_SPLIT + GAIN_W;
    localparam int SUM_W      = MAG_W + GAIN_W + 1;
    localparam int GAIN_SH    = GAIN_FRAC - GUARD_BITS;
    localparam int PROD_W     = SUM_W - GAIN_SH;
    localparam logic [SUM_W-1:0] GAIN_ROUND = SUM_W'(1) << (GAIN_SH - 1);

    localparam int XW = CW + GUARD_BITS + 3;
    localparam int ZW = 32;
    localparam int FW = XW - GUARD_BITS + 1;
    localparam int RES_W = ANGLE_W - 2;
    localparam int Z_SH  = TURN_W - ANGLE_W;

    localparam logic [ANGLE_W-1:0] HALF_QUARTER = ANGLE_W'(1) << (ANGLE_W - 3);
    localparam logic [XW-1:0]      ROUND_HALF   = XW'(1) << (GUARD_BITS - 1);

    localparam logic signed [CW-1:0] COORD_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_LO = {1'b1, {(CW-1){1'b0}}};
    localparam logic [FIELD_W-1:0] COORD_HI_OUT = FIELD_W'(COORD_HI);
    localparam logic [FIELD_W-1:0] COORD_LO_OUT = FIELD_W'(COORD_LO);

    // atan(2^-i) in 1/2^32 turn
    localparam logic [TURN_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] center_x;
        logic signed [FIELD_W-1:0] center_y;
        logic        [ANGLE_W-1:0] turn_angle;
    } in_word_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] rotated_x;
        logic signed [FIELD_W-1:0] rotated_y;
        logic                      clipped;
    } out_word_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } rot_word_t;

    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 hit;
    } sat_t;

    function automatic sat_t saturate(input logic signed [FW-1:0] v);
        sat_t res;
        res.hit   = 1'b1;
        res.value = COORD_HI;
        if (v > FW'(COORD_HI)) begin
            res.value = COORD_HI;
        end else if (v < FW'(COORD_LO)) begin
            res.value = COORD_LO;
        end else begin
            res.value = v[CW-1:0];
            res.hit   = 1'b0;
        end
        return res;
    endfunction

endpackage

FILE: rtl/rpc_gain.sv
// ----------------------------------------------------------------------------
// rpc_gain
// offset, quarter-turn swap and gain scaling, three register stages
// ----------------------------------------------------------------------------
module rpc_gain (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpc_pkg::in_word_t  s_word,
    output logic               out_valid,
    input  logic               out_ready,
    output rpc_pkg::rot_word_t out_word
);
    import rpc_pkg::*;

    logic signed [CW-1:0]  px, py, cx, cy;
    logic signed [CW:0]    dx, dy;
    logic [MAG_W-1:0]      mag_dx, mag_dy;
    logic [ANGLE_W-1:0]    angle_bias;
    quad_t                 quad;
    logic signed [RES_W-1:0] residual;
    logic signed [ZW-1:0]  z_init;
    logic [MAG_W-1:0]      mag_a, mag_b;
    logic                  neg_a, neg_b;

    logic                  rdy1, rdy2, rdy3;

    logic                  s1_valid_reg;
    logic [MAG_W-1:0]      s1_mag_x_reg, s1_mag_y_reg;
    logic                  s1_neg_x_reg, s1_neg_y_reg;
    logic signed [ZW-1:0]  s1_z_reg;
    logic signed [CW-1:0]  s1_cx_reg, s1_cy_reg;

    logic                  s2_valid_reg;
    logic [PROD_HI_W-1:0]  s2_hi_x_reg, s2_hi_y_reg;
    logic [PROD_LO_W-1:0]  s2_lo_x_reg, s2_lo_y_reg;
    logic                  s2_neg_x_reg, s2_neg_y_reg;
    logic signed [ZW-1:0]  s2_z_reg;
    logic signed [CW-1:0]  s2_cx_reg, s2_cy_reg;

    logic [SUM_W-1:0]      sum_x, sum_y;
    logic [PROD_W-1:0]     p_x, p_y;
    logic signed [XW-1:0]  g_x, g_y;
    rot_word_t             s3_word_next;

    logic                  s3_valid_reg;
    rot_word_t             s3_word_reg;

    // stage 1: offsets, magnitudes, quarter turns, residual angle
    always_comb begin
        px = s_word.point_x[CW-1:0];
        py = s_word.point_y[CW-1:0];
        cx = s_word.center_x[CW-1:0];
        cy = s_word.center_y[CW-1:0];
        dx = (CW+1)'(px) - (CW+1)'(cy - cy + cx);
        dy = (CW+1)'(py) - (CW+1)'(cy);
        mag_dx = dx[CW] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_dy = dy[CW] ? MAG_W'(-dy) : MAG_W'(dy);

        angle_bias = s_word.turn_angle + HALF_QUARTER;
        quad       = quad_t'(angle_bias[ANGLE_W-1:ANGLE_W-2]);
        // remainder in -1/8..1/8 turn: recenter the low bits
        residual   = $signed({~angle_bias[RES_W-1], angle_bias[RES_W-2:0]});
        z_init     = ZW'($signed({residual, {Z_SH{1'b0}}}));

        unique case (quad)
            QUAD_0: begin
                mag_a = mag_dx; neg_a = dx[CW];
                mag_b = mag_dy; neg_b = dy[CW];
            end
            QUAD_90: begin
                mag_a = mag_dy; neg_a = ~dy[CW];
                mag_b = mag_dx; neg_b = dx[CW];
            end
            QUAD_180: begin
                mag_a = mag_dx; neg_a = ~dx[CW];
                mag_b = mag_dy; neg_b = ~dy[CW];
            end
            QUAD_270: begin
                mag_a = mag_dy; neg_a = dy[CW];
                mag_b = mag_dx; neg_b = ~dx[CW];
            end
            default: begin
                mag_a = mag_dx; neg_a = dx[CW];
                mag_b = mag_dy; neg_b = dy[CW];
            end
        endcase
    end

    // stage 3: recombine partial products, round, restore sign
    always_comb begin
        sum_x = (SUM_W'(s2_hi_x_reg) << MUL_SPLIT) + SUM_W'(s2_lo_x_reg) + GAIN_ROUND;
        sum_y = (SUM_W'(s2_hi_y_reg) << MUL_SPLIT) + SUM_W'(s2_lo_y_reg) + GAIN_ROUND;
        p_x   = sum_x[SUM_W-1:GAIN_SH];
        p_y   = sum_y[SUM_W-1:GAIN_SH];
        g_x   = $signed(XW'(p_x));
        g_y   = $signed(XW'(p_y));
        s3_word_next.x  = s2_neg_x_reg ? -g_x : g_x;
        s3_word_next.y  = s2_neg_y_reg ? -g_y : g_y;
        s3_word_next.z  = s2_z_reg;
        s3_word_next.cx = s2_cx_reg;
        s3_word_next.cy = s2_cy_reg;
    end

    assign rdy3    = !s3_valid_reg || out_ready;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign rdy1    = !s1_valid_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_valid;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_mag_x_reg <= mag_a;
            s1_neg_x_reg <= neg_a;
            s1_mag_y_reg <= mag_b;
            s1_neg_y_reg <= neg_b;
            s1_z_reg     <= z_init;
            s1_cx_reg    <= cx;
            s1_cy_reg    <= cy;
        end
        if (rdy2) begin
            // split magnitude so each product stays within a 32x32 multiplier
            s2_hi_x_reg  <= PROD_HI_W'(s1_mag_x_reg[MAG_W-1:MUL_SPLIT]) * PROD_HI_W'(GAIN_Q30);
            s2_lo_x_reg  <= PROD_LO_W'(s1_mag_x_reg[MUL_SPLIT-1:0]) * PROD_LO_W'(GAIN_Q30);
            s2_hi_y_reg  <= PROD_HI_W'(s1_mag_y_reg[MAG_W-1:MUL_SPLIT]) * PROD_HI_W'(GAIN_Q30);
            s2_lo_y_reg  <= PROD_LO_W'(s1_mag_y_reg[MUL_SPLIT-1:0]) * PROD_LO_W'(GAIN_Q30);
            s2_neg_x_reg <= s1_neg_x_reg;
            s2_neg_y_reg <= s1_neg_y_reg;
            s2_z_reg     <= s1_z_reg;
            s2_cx_reg    <= s1_cx_reg;
            s2_cy_reg    <= s1_cy_reg;
        end
        if (rdy3) begin
            s3_word_reg <= s3_word_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_word  = s3_word_reg;

endmodule

FILE: rtl/rpc_cordic.sv
// ----------------------------------------------------------------------------
// rpc_cordic
// unrolled cordic rotation, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module rpc_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpc_pkg::rot_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output rpc_pkg::rot_word_t out_word
);
    import rpc_pkg::*;

    rot_word_t             word_reg  [N_STAGES];
    rot_word_t             word_next [N_STAGES];
    logic [N_STAGES-1:0]   valid_reg;
    logic [N_STAGES-1:0]   valid_prev;
    logic [N_STAGES-1:0]   rdy;

    for (genvar i = 0; i < N_STAGES; i++) begin : g_stage
        rot_word_t            prev;
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] step;
        logic                 z_neg;

        if (i == 0) begin : g_first
            assign prev          = in_word;
            assign valid_prev[i] = in_valid;
        end else begin : g_rest
            assign prev          = word_reg[i-1];
            assign valid_prev[i] = valid_reg[i-1];
        end

        if (i == N_STAGES - 1) begin : g_last
            assign rdy[i] = !valid_reg[i] || out_ready;
        end else begin : g_mid
            assign rdy[i] = !valid_reg[i] || rdy[i+1];
        end

        assign xs    = prev.x >>> i;
        assign ys    = prev.y >>> i;
        assign step  = $signed(ZW'(ATAN_TURNS[i]));
        assign z_neg = prev.z[ZW-1];

        assign word_next[i] = '{
            x:  z_neg ? prev.x + ys : prev.x - ys,
            y:  z_neg ? prev.y - xs : prev.y + xs,
            z:  z_neg ? prev.z + step : prev.z - step,
            cx: prev.cx,
            cy: prev.cy
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < N_STAGES; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_prev[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N_STAGES; i++) begin
            if (rdy[i]) begin
                word_reg[i] <= word_next[i];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N_STAGES-1];
    assign out_word  = word_reg[N_STAGES-1];

endmodule

FILE: rtl/rpc_finish.sv
// ----------------------------------------------------------------------------
// rpc_finish
// drop guard bits, add the center back, saturate; output register
// ----------------------------------------------------------------------------
module rpc_finish (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpc_pkg::rot_word_t in_word,
    output logic               m_valid,
    input  logic               m_ready,
    output rpc_pkg::out_word_t m_word
);
    import rpc_pkg::*;

    logic signed [XW-1:0]            x_bias, y_bias;
    logic signed [XW-GUARD_BITS-1:0] x_rnd, y_rnd;
    logic signed [FW-1:0]            x_sum, y_sum;
    sat_t                            x_sat, y_sat;
    out_word_t                       word_next;

    logic                            m_valid_reg;
    out_word_t                       m_word_reg;

    always_comb begin
        x_bias = in_word.x + $signed(ROUND_HALF);
        y_bias = in_word.y + $signed(ROUND_HALF);
        x_rnd  = $signed(x_bias[XW-1:GUARD_BITS]);
        y_rnd  = $signed(y_bias[XW-1:GUARD_BITS]);
        x_sum  = FW'(x_rnd) + FW'(in_word.cx);
        y_sum  = FW'(y_rnd) + FW'(in_word.cy);
        x_sat  = saturate(x_sum);
        y_sat  = saturate(y_sum);
        word_next.rotated_x = FIELD_W'(x_sat.value);
        word_next.rotated_y = FIELD_W'(y_sat.value);
        word_next.clipped   = x_sat.hit | y_sat.hit;
    end

    assign in_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            m_word_reg <= word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: rtl/rotate_point_about_center.sv
// ----------------------------------------------------------------------------
// rotate_point_about_center
// rotates a Q16.16 point about a center by a binary angle (cordic pipeline)
//
//   channel   ports                         word
//   input     s_valid / s_ready / s_word    point, center, turn_angle
//   result    m_valid / m_ready / m_word    rotated point, clipped flag
//
// one point per cycle while m_ready does not stall the output; the pipe is made of
// the gain stages, one register per cordic micro-rotation and the
// output register. synchronous active-low reset empties every stage.
// each stage holds its word while the one after it is full and stalled,
// so a stall at m_ready backs up stage by stage and bubbles are squeezed out.
// ----------------------------------------------------------------------------
`include "rotate_point_about_center_macros.svh"

module rotate_point_about_center (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpc_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output rpc_pkg::out_word_t m_word
);
    import rpc_pkg::*;

    logic      gain_valid, gain_ready;
    rot_word_t gain_word;
    logic      rot_valid, rot_ready;
    rot_word_t rot_word;

    rpc_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .out_valid (gain_valid),
        .out_ready (gain_ready),
        .out_word  (gain_word)
    );

    rpc_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (gain_valid),
        .in_ready  (gain_ready),
        .in_word   (gain_word),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_word  (rot_word)
    );

    rpc_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rot_valid),
        .in_ready (rot_ready),
        .in_word  (rot_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

    // back-pressure can only start at a stalled output word
    `RPC_CHECK_SAME(a_stall_from_output, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without a stalled output word")

    // a clipped word carries a bound in at least one coordinate
    `RPC_CHECK_SAME(a_clip_at_bound, aclk, aresetn, m_valid && m_word.clipped, (m_word.rotated_x == COORD_HI_OUT) || (m_word.rotated_x == COORD_LO_OUT) || (m_word.rotated_y == COORD_HI_OUT) || (m_word.rotated_y == COORD_LO_OUT), "clipped set with no saturated coordinate")

    // reset empties the whole pipe
    `RPC_CHECK_NEXT(a_empty_after_reset, aclk, !aresetn, !m_valid && s_ready && !rot_valid && !gain_valid, "pipeline not empty after reset")

endmodule
